// ===== rtl/acd_pkg.sv =====
// ----------------------------------------------------------------------------
// acd_pkg
// Shared types and constants of the aging cache directory.
// ----------------------------------------------------------------------------
package acd_pkg;

    // Default number of directory slots
    localparam int ACD_ENTRIES = 64;

    localparam int AGE_W  = 16;
    localparam int STEP_W = 8;

    // Request modes
    localparam logic [1:0] MODE_LOOKUP  = 2'd0;
    localparam logic [1:0] MODE_INSERT  = 2'd1;
    localparam logic [1:0] MODE_INV_VOL = 2'd2;
    localparam logic [1:0] MODE_INV_ALL = 2'd3;

    // Configuration register indexes
    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_DIR_AGE_STEP  = 1'd0;
    localparam t_cfg_idx CFG_FILE_AGE_STEP = 1'd1;

    localparam logic [STEP_W-1:0] DIR_STEP_RST  = 8'd1;
    localparam logic [STEP_W-1:0] FILE_STEP_RST = 8'd10;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  volume;
        logic [31:0] dev;
        logic [31:0] inode;
        logic        is_dir;
        logic        volume_changed;
    } t_req;

    typedef struct packed {
        logic       hit;
        logic [5:0] slot;
        logic       evicted;
        logic [6:0] used_count;
    } t_rsp;

    // One stored directory entry (valid bits live in flops)
    typedef struct packed {
        logic [7:0]       volume;
        logic [31:0]      dev;
        logic [31:0]      inode;
        logic             is_dir;
        logic [AGE_W-1:0] age;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

endpackage

// ===== rtl/acd_if.sv =====
// ----------------------------------------------------------------------------
// acd_req_if / acd_rsp_if
// Valid/ready channels carrying directory requests and responses.
// ----------------------------------------------------------------------------
interface acd_req_if;
    import acd_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface acd_rsp_if;
    import acd_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/aging_cache_directory_top.sv =====
// ----------------------------------------------------------------------------
// aging_cache_directory_top
// Directory of cached entries tagged by volume, device and inode, with
// idle aging, first-free / append / oldest-eviction insert and invalidation.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake           Payload
//  --------  ---  ------------------  -----------------------------------------
//  i_req     in   valid/ready         mode, volume, dev, inode, is_dir,
//                                     volume_changed
//  o_rsp     out  valid/ready         hit, slot, evicted, used_count
//  i_cfg_*   in   write enable only   dir_age_step (0), file_age_step (1)
//
//  One request is in work at a time. A lookup, insert or volume invalidate
//  does one entry RAM read per cycle over the slots below the high-water
//  count, then writes the result in its finish state. A lookup stops at its
//  first hit; invalidate-all and forced-miss lookups skip the scan.
//  Reset is synchronous; it clears all valid bits and the high-water count
//  directly in their flops, so no clearing pass is needed.
//  A response that is not taken holds the block in its finish state; the
//  transfer register on o_rsp decouples the two sides by one entry.
// ----------------------------------------------------------------------------
module aging_cache_directory_top #(
    parameter int ENTRIES = acd_pkg::ACD_ENTRIES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    acd_req_if.sink           i_req,
    acd_rsp_if.source         o_rsp,
    input  logic              i_cfg_we,
    input  acd_pkg::t_cfg_idx i_cfg_idx,
    input  logic [7:0]        i_cfg_data
);
    import acd_pkg::*;

    // slot index and high-water count widths
    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int EW = $bits(t_entry);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state              r_state, n_state;
    logic [ENTRIES-1:0]  r_valid, n_valid;
    logic [CW-1:0]       r_high_water, n_high_water;
    logic [STEP_W-1:0]   r_dir_step, r_file_step;
    logic [CW-1:0]       r_left, n_left;        // reads still to issue
    logic                r_chk, n_chk;          // RAM output holds an entry to check
    logic                r_out_valid, n_out_valid;

    t_req                r_req, n_req;
    logic [IW-1:0]       r_addr, n_addr;
    logic [IW-1:0]       r_chk_idx, n_chk_idx;
    logic                r_have_free, n_have_free;
    logic [IW-1:0]       r_free_slot, n_free_slot;
    logic [AGE_W-1:0]    r_max_age, n_max_age;
    logic [IW-1:0]       r_old_slot, n_old_slot;
    logic                r_hit, n_hit;
    logic [IW-1:0]       r_hit_slot, n_hit_slot;
    t_rsp                r_out, n_out;

    // ------------------------------------------------------------------
    // Entry RAM
    // ------------------------------------------------------------------
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    t_entry        ram_wdata;
    t_entry        ram_rdata;

    acd_ram #(
        .WIDTH (EW),
        .DEPTH (ENTRIES),
        .AW    (IW)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Handshakes and entry checks
    // ------------------------------------------------------------------
    logic req_xfer;
    logic out_free;
    logic start_short;   // request needs no scan
    logic ent_valid;
    logic vol_match;
    logic tag_match;
    logic lookup_match;

    assign i_req.ready = (r_state == ST_IDLE);
    assign req_xfer    = i_req.valid && i_req.ready;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;
    assign out_free    = !r_out_valid || o_rsp.ready;

    assign start_short = (i_req.data.mode == MODE_INV_ALL)
                      || ((i_req.data.mode == MODE_LOOKUP) && i_req.data.volume_changed)
                      || (r_high_water == '0);

    assign ent_valid    = r_valid[r_chk_idx];
    assign vol_match    = (ram_rdata.volume == r_req.volume);
    assign tag_match    = vol_match && (ram_rdata.dev == r_req.dev)
                       && (ram_rdata.inode == r_req.inode);
    assign lookup_match = (r_state == ST_SCAN) && r_chk && (r_req.mode == MODE_LOOKUP)
                       && ent_valid && tag_match;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (req_xfer) begin
                    n_state = start_short ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                // last read already issued: this cycle checks the final entry
                if (lookup_match || (r_left == '0)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and outputs
    // ------------------------------------------------------------------
    always_comb begin
        logic [STEP_W-1:0] step;
        logic [AGE_W:0]    age_sum;
        logic [AGE_W-1:0]  aged;
        logic [IW-1:0]     target;
        logic              evict;
        logic [CW-1:0]     hw_next;
        logic [15:0]       slot_wide;
        logic [15:0]       used_wide;

        n_valid      = r_valid;
        n_high_water = r_high_water;
        n_left       = r_left;
        n_chk        = r_chk;
        n_out_valid  = r_out_valid;
        n_req        = r_req;
        n_addr       = r_addr;
        n_chk_idx    = r_chk_idx;
        n_have_free  = r_have_free;
        n_free_slot  = r_free_slot;
        n_max_age    = r_max_age;
        n_old_slot   = r_old_slot;
        n_hit        = r_hit;
        n_hit_slot   = r_hit_slot;
        n_out        = r_out;

        ram_we    = 1'b0;
        ram_waddr = r_chk_idx;
        ram_wdata = ram_rdata;

        step      = ram_rdata.is_dir ? r_dir_step : r_file_step;
        age_sum   = {1'b0, ram_rdata.age} + {{(AGE_W + 1 - STEP_W){1'b0}}, step};
        aged      = age_sum[AGE_W] ? {AGE_W{1'b1}} : age_sum[AGE_W-1:0];
        target    = '0;
        evict     = 1'b0;
        hw_next   = r_high_water;
        slot_wide = '0;
        used_wide = '0;

        // drop the response once it is taken
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (req_xfer) begin
                    n_req       = i_req.data;
                    n_have_free = 1'b0;
                    n_free_slot = '0;
                    n_max_age   = '0;
                    n_old_slot  = '0;
                    n_hit       = 1'b0;
                    n_hit_slot  = '0;
                    n_chk       = 1'b0;
                    if (i_req.data.mode == MODE_INV_ALL) begin
                        n_valid      = '0;
                        n_high_water = '0;
                        n_left       = '0;
                    end else if (start_short) begin
                        n_left = '0;
                    end else begin
                        n_left = r_high_water;
                        // volume invalidation walks from the top slot down
                        if (i_req.data.mode == MODE_INV_VOL) begin
                            hw_next = r_high_water - CW'(1);
                            n_addr  = hw_next[IW-1:0];
                        end else begin
                            n_addr = '0;
                        end
                    end
                end
            end

            ST_SCAN: begin
                // issue the next read
                if (r_left != '0) begin
                    n_addr    = (r_req.mode == MODE_INV_VOL) ? r_addr - IW'(1)
                                                             : r_addr + IW'(1);
                    n_left    = r_left - CW'(1);
                    n_chk     = 1'b1;
                    n_chk_idx = r_addr;
                end else begin
                    n_chk = 1'b0;
                end

                // check the entry that the RAM returns
                if (r_chk) begin
                    case (r_req.mode)
                        MODE_LOOKUP: begin
                            if (lookup_match) begin
                                n_hit         = 1'b1;
                                n_hit_slot    = r_chk_idx;
                                ram_we        = 1'b1;
                                ram_wdata.age = '0;
                                n_left        = '0;
                                n_chk         = 1'b0;
                            end
                        end
                        MODE_INSERT: begin
                            if (!ent_valid) begin
                                if (!r_have_free) begin
                                    n_have_free = 1'b1;
                                    n_free_slot = r_chk_idx;
                                end
                            end else begin
                                ram_we        = 1'b1;
                                ram_wdata.age = aged;
                                if (aged > r_max_age) begin
                                    n_max_age  = aged;
                                    n_old_slot = r_chk_idx;
                                end
                            end
                        end
                        MODE_INV_VOL: begin
                            if (ent_valid && vol_match) begin
                                n_valid[r_chk_idx] = 1'b0;
                                // lower the count only while the top slot empties
                                if ((CW'(r_chk_idx) + CW'(1)) == r_high_water) begin
                                    n_high_water = r_high_water - CW'(1);
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_FINISH: begin
                if (out_free) begin
                    if (r_req.mode == MODE_INSERT) begin
                        if (r_have_free) begin
                            target = r_free_slot;
                        end else if (r_high_water != CW'(ENTRIES)) begin
                            target  = r_high_water[IW-1:0];
                            hw_next = r_high_water + CW'(1);
                        end else begin
                            target = r_old_slot;
                            evict  = 1'b1;
                        end
                        ram_we           = 1'b1;
                        ram_waddr        = target;
                        ram_wdata.volume = r_req.volume;
                        ram_wdata.dev    = r_req.dev;
                        ram_wdata.inode  = r_req.inode;
                        ram_wdata.is_dir = r_req.is_dir;
                        ram_wdata.age    = '0;
                        n_valid[target]  = 1'b1;
                        n_high_water     = hw_next;
                    end else if (r_req.mode == MODE_LOOKUP) begin
                        target = r_hit_slot;
                    end
                    slot_wide = 16'(target);
                    used_wide = 16'(hw_next);

                    n_out_valid      = 1'b1;
                    n_out.hit        = r_hit;
                    n_out.slot       = slot_wide[5:0];
                    n_out.evicted    = evict;
                    n_out.used_count = used_wide[6:0];
                end
            end

            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_valid      <= '0;
            r_high_water <= '0;
            r_dir_step   <= DIR_STEP_RST;
            r_file_step  <= FILE_STEP_RST;
            r_left       <= '0;
            r_chk        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_valid      <= n_valid;
            r_high_water <= n_high_water;
            r_left       <= n_left;
            r_chk        <= n_chk;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DIR_AGE_STEP:  r_dir_step  <= i_cfg_data;
                    CFG_FILE_AGE_STEP: r_file_step <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_addr      <= n_addr;
        r_chk_idx   <= n_chk_idx;
        r_have_free <= n_have_free;
        r_free_slot <= n_free_slot;
        r_max_age   <= n_max_age;
        r_old_slot  <= n_old_slot;
        r_hit       <= n_hit;
        r_hit_slot  <= n_hit_slot;
        r_out       <= n_out;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_hw_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_high_water <= CW'(ENTRIES))
        else $error("high-water count beyond the slot count");

    a_valid_below_hw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid >> r_high_water) == '0)
        else $error("live slot at or above the high-water count");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !ram_we)
        else $error("entry RAM written while idle");

    a_inv_all_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_xfer && (i_req.data.mode == MODE_INV_ALL)) |=>
            ((r_valid == '0) && (r_high_water == '0)))
        else $error("invalidate-all left live slots");

    a_finish_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_FINISH) && r_out_valid && !o_rsp.ready) |=>
            (r_state == ST_FINISH))
        else $error("result finished over an untaken response");

endmodule

// ===== rtl/acd_ram.sv =====
// ----------------------------------------------------------------------------
// acd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module acd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
